[design/bmhs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmhs_pkg: shared types and constants of the heap sorter
// Transfer structs, the stored element layout and the sequencer states.
// ----------------------------------------------------------------------------
package bmhs_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int KEY_W            = 32;
  localparam int PAYLOAD_W        = 32;
  localparam int ELEM_W           = KEY_W + PAYLOAD_W;

  typedef struct packed {
    logic signed [KEY_W-1:0] sort_key;
    logic [PAYLOAD_W-1:0]    payload;
    logic                    last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic [PAYLOAD_W-1:0]    sorted_payload;
    logic                    last_result;
    logic                    overflow;
  } out_item_t;

  // One element as held in the store.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload;
  } elem_t;

  typedef enum logic [3:0] {
    S_LOAD,   // collecting the batch
    S_HRD,    // heapify: read the node to sift
    S_HCUR,   // heapify: capture that node
    S_SA,     // sift: test for children, read left child
    S_SB,     // sift: compare against left child, read right child
    S_SC,     // sift: compare against right child, move one level
    S_POP,    // pop: read the root
    S_PRD,    // pop: emit the root, read the last element
    S_PLST    // pop: last element becomes the element to sift from the root
  } state_t;

endpackage : bmhs_pkg
`default_nettype wire

[design/bmhs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmhs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmhs_ram import bmhs_pkg::*; #(
  parameter int WIDTH = ELEM_W,
  parameter int DEPTH = CAPACITY_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : bmhs_ram
`default_nettype wire

[design/binary_min_heap_sort.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_sort: batch heapsort of key/payload elements
// Collects a batch, builds a min-heap in a RAM and pops it in key order.
// ----------------------------------------------------------------------------
// Usage. Elements come in on the in_ channel (valid/ready), one per transfer.
// While the block collects a batch it takes one transfer per cycle and
// writes the element into the RAM. Elements beyond CAPACITY are dropped and
// the whole sorted run is then marked with overflow. The transfer that
// carries last_item closes the batch; in_ready then stays low until every
// sorted element has been handed to the out_ register stage.
// Sorting uses one RAM read port and one signed key comparator under a
// small sequencer. Each sift level reads the left child, compares it, then
// compares the right child and moves. Heapify runs n/2 sifts, each after a
// setup that reads and captures its node; every pop reads the root, emits
// it and reads the last element, then sifts that element from the root.
// Results leave through an output register. When the receiver stalls, the
// sequencer waits at the next pop; nothing is lost or repeated. The last
// result of a run may still wait while the next batch is already loading.
// Reset (rst_n low, synchronous) empties the batch and the output register.
// ----------------------------------------------------------------------------
module binary_min_heap_sort import bmhs_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Count width holds 0..CAPACITY; child positions need one more bit.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = CW + 1;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;       // elements stored in this batch
  logic           drop_r, drop_nxt;     // an element of this batch was dropped
  logic [CW-1:0]  n_r, n_nxt;           // current heap size
  logic [CW-1:0]  pos_r, pos_nxt;       // node the sift works on (1-indexed)
  logic [CW-1:0]  hp_r, hp_nxt;         // heapify node counter
  logic           heap_mode_r, heap_mode_nxt;
  elem_t          cur_r, cur_nxt;       // element being sifted down
  elem_t          best_r, best_nxt;     // smaller of cur and left child
  logic           pick_c0_r, pick_c0_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_item_t      out_r, out_nxt;

  // RAM port signals
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  elem_t          ram_wdata;
  logic [AW-1:0]  ram_raddr;
  elem_t          ram_rdata;

  // Shared comparator and sift bookkeeping
  logic [KEY_W-1:0] cmp_a;
  logic             gt;
  logic [NW-1:0]    c0, c1, n_ext;
  logic             sift_done;
  logic             full;
  logic [CW-1:0]    n_new;

  bmhs_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign c0    = {pos_r, 1'b0};
  assign c1    = {pos_r, 1'b1};
  assign n_ext = {1'b0, n_r};
  assign full  = (cnt_r == CW'(CAPACITY));

  // The one key comparator: in the left-child step it weighs the sifted
  // element against the left child, in the right-child step the winner so far
  // against the right child.
  assign cmp_a = (state_r == S_SB) ? cur_r.key : best_r.key;
  assign gt    = ($signed(cmp_a) > $signed(ram_rdata.key));

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    hp_nxt        = hp_r;
    heap_mode_nxt = heap_mode_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    pick_c0_nxt   = pick_c0_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = AW'(pos_r - CW'(1));
    ram_wdata     = cur_r;
    ram_raddr     = '0;
    sift_done     = 1'b0;
    n_new         = cnt_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (!full) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(cnt_r);
            ram_wdata = '{key: in_data.sort_key, payload: in_data.payload};
            cnt_nxt   = cnt_r + CW'(1);
            n_new     = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            n_nxt = n_new;
            hp_nxt = n_new >> 1;
            heap_mode_nxt = 1'b1;
            // A single element is already a heap.
            if ((n_new >> 1) == '0) begin
              state_nxt = S_POP;
            end else begin
              state_nxt = S_HRD;
            end
          end
        end
      end

      S_HRD: begin
        ram_raddr = AW'(hp_r - CW'(1));
        pos_nxt   = hp_r;
        state_nxt = S_HCUR;
      end

      S_HCUR: begin
        cur_nxt   = ram_rdata;
        state_nxt = S_SA;
      end

      S_SA: begin
        if (c0 > n_ext) begin
          // Leaf: the sifted element settles here.
          ram_we    = 1'b1;
          sift_done = 1'b1;
        end else begin
          ram_raddr = AW'(c0 - NW'(1));
          state_nxt = S_SB;
        end
      end

      S_SB: begin
        if (gt) begin
          best_nxt    = ram_rdata;
          pick_c0_nxt = 1'b1;
        end else begin
          best_nxt    = cur_r;
          pick_c0_nxt = 1'b0;
        end
        if (c1 <= n_ext) begin
          ram_raddr = AW'(c1 - NW'(1));
        end
        state_nxt = S_SC;
      end

      S_SC: begin
        if ((c1 <= n_ext) && gt) begin
          // Right child moves up into this node.
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = CW'(c1);
          state_nxt = S_SA;
        end else if (pick_c0_r) begin
          ram_we    = 1'b1;
          ram_wdata = best_r;
          pos_nxt   = CW'(c0);
          state_nxt = S_SA;
        end else begin
          ram_we    = 1'b1;
          sift_done = 1'b1;
        end
      end

      S_POP: begin
        if (n_r == '0) begin
          // Run complete: start a new batch.
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          ram_raddr = '0;
          state_nxt = S_PRD;
        end
      end

      S_PRD: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.sorted_key     = ram_rdata.key;
          out_nxt.sorted_payload = ram_rdata.payload;
          out_nxt.last_result    = (n_r == CW'(1));
          out_nxt.overflow       = drop_r;
          out_valid_nxt          = 1'b1;
          ram_raddr              = AW'(n_r - CW'(1));
          state_nxt              = S_PLST;
        end else begin
          // Keep re-reading the root until the output register frees up.
          ram_raddr = '0;
        end
      end

      S_PLST: begin
        cur_nxt       = ram_rdata;
        n_nxt         = n_r - CW'(1);
        pos_nxt       = CW'(1);
        heap_mode_nxt = 1'b0;
        state_nxt     = S_SA;
      end

      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (sift_done) begin
      if (heap_mode_r && (hp_r != CW'(1))) begin
        hp_nxt    = hp_r - CW'(1);
        state_nxt = S_HRD;
      end else begin
        heap_mode_nxt = 1'b0;
        state_nxt     = S_POP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      n_r         <= '0;
      pos_r       <= '0;
      hp_r        <= '0;
      heap_mode_r <= 1'b0;
      pick_c0_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      n_r         <= n_nxt;
      pos_r       <= pos_nxt;
      hp_r        <= hp_nxt;
      heap_mode_r <= heap_mode_nxt;
      pick_c0_r   <= pick_c0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    best_r <= best_nxt;
    out_r  <= out_nxt;
  end

endmodule : binary_min_heap_sort
`default_nettype wire
